// ----- hw/rtl/gbcd_pkg.sv -----
package gbcd_pkg;

  // fixed-point and range constants
  localparam int FRAC_BITS   = 8;
  localparam int MAX_SAMPLES = 1024;

  localparam int CNT_W  = 11;  // sample count, counter, divisor
  localparam int RAW_W  = 16;
  localparam int SUM_W  = 27;
  localparam int SQ_W   = 41;
  localparam int SQR_W  = 32;  // one raw square
  localparam int VAR_W  = 51;  // n*sumsq and sum^2
  localparam int OFF_W  = 35;  // covers a run cut short by a lowered count
  localparam int SPR_W  = 24;
  localparam int RATE_W = 21;
  localparam int GAIN_W = 20;
  localparam int PROD_W = OFF_W + GAIN_W + 1;
  localparam int QMAG_W = PROD_W - FRAC_BITS - 16;
  localparam int THR_W  = SPR_W + 8;
  localparam int MULT_W = 8;

  // shared sqrt / divide unit
  localparam int X_W   = 68;  // radicand scaled by 2^(2*FRAC_BITS), or dividend
  localparam int R_W   = 37;
  localparam int Q_W   = 35;
  localparam int ITC_W = 6;
  localparam int SQRT_STEPS = X_W / 2;
  localparam int DIV_STEPS  = Q_W;

  localparam logic [RATE_W-1:0] RATE_MAX_MAG = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [SPR_W-1:0]  SPREAD_MAX   = {SPR_W{1'b1}};

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_SCALE        = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_CAL_MUL,
    ST_CAL_SUB,
    ST_CAL_SQRT,
    ST_CAL_DIVS,
    ST_CAL_DIVO,
    ST_MEAS_MUL,
    ST_MEAS_RND,
    ST_FINISH
  } state_t;

  // dps per digit in Q24 for each full scale
  function automatic logic [GAIN_W-1:0] gain_q24(input logic [1:0] sel);
    logic [GAIN_W-1:0] g;
    case (sel)
      2'd0:    g = GAIN_W'(128060);
      2'd1:    g = GAIN_W'(256138);
      2'd2:    g = GAIN_W'(511487);
      default: g = GAIN_W'(1022991);
    endcase
    return g;
  endfunction

endpackage

// ----- hw/rtl/gbcd_iter.sv -----
// Shared one-bit-per-cycle unit: integer square root (two radicand bits a
// cycle) or restoring division by the sample count.
module gbcd_iter import gbcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  unit_req_t        req,
  input  logic [VAR_W-1:0] radicand,
  input  logic [Q_W-1:0]   dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   result
);

  logic [X_W-1:0]   x;
  logic [R_W-1:0]   r;
  logic [Q_W-1:0]   q;
  logic [ITC_W-1:0] cnt;
  logic             busy;
  op_t              op;

  logic [R_W-1:0] remc;
  logic [R_W-1:0] trial;
  logic           ge;

  // one step of the shared compare and subtract
  always_comb begin
    if (op == OP_SQRT) begin
      remc  = {r[R_W-3:0], x[X_W-1 -: 2]};
      trial = {1'b0, q[Q_W-2:0], 2'b01};
    end else begin
      remc  = {r[R_W-2:0], x[X_W-1]};
      trial = {{(R_W-CNT_W){1'b0}}, divisor};
    end
    ge = (remc >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        r    <= '0;
        q    <= '0;
        if (req.op == OP_SQRT) begin
          x   <= {1'b0, radicand, {(2*FRAC_BITS){1'b0}}};
          cnt <= ITC_W'(SQRT_STEPS);
        end else begin
          x   <= {dividend, {(X_W-Q_W){1'b0}}};
          cnt <= ITC_W'(DIV_STEPS);
        end
      end else if (busy) begin
        r   <= ge ? (remc - trial) : remc;
        q   <= {q[Q_W-2:0], ge};
        x   <= (op == OP_SQRT) ? {x[X_W-3:0], 2'b00} : {x[X_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == ITC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = q;

endmodule

// ----- hw/rtl/gyro_bias_calibrate_deadband_core.sv -----
// Channel  Direction  Payload
// s_*      in         s_tdata: gyro_x, gyro_y, gyro_z; s_tuser: func
// m_*      out        m_tdata: rate_x, rate_y, rate_z; m_tuser: calib_done, is_calibrated
// cfg_*    in         cfg_index (0 count, 1 threshold, 2 scale), cfg_data
//
// One sample in flight at a time. Measure sample: a multiply and a rounding state
// per axis, then the output. Calibration sample: an accumulate step, and on the
// sample that ends a run, per axis a 34-step square root and two 35-step divides
// in the shared bit-serial unit. Synchronous reset clears sums, offsets, spreads
// and flags. A finished result waits in the output register while a new
// sample is accepted; a full output register holds the sequencer.
module gyro_bias_calibrate_deadband_core import gbcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // gyro_x[15:0], gyro_y[31:16], gyro_z[47:32]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // rate_x[20:0], rate_y[41:21], rate_z[62:42], zero pad
  output logic [1:0]  m_tuser,   // calib_done[0], is_calibrated[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  state_t state, state_next;

  // configuration
  logic [CNT_W-1:0]  sample_count;
  logic [MULT_W-1:0] threshold_multiple;
  logic [1:0]        scale_select;

  // calibration state
  logic signed [SUM_W-1:0] axis_sum [3];
  logic [SQ_W-1:0]         axis_sum_squares [3];
  logic [CNT_W-1:0]        sample_counter;
  logic signed [OFF_W-1:0] axis_offset [3];
  logic [SPR_W-1:0]        axis_spread [3];
  logic                    calibrated_flag;

  // request holding and working registers
  logic                    func;
  logic signed [RAW_W-1:0] raw [3];
  logic [1:0]              axis;
  logic [VAR_W-1:0]        lhs, rhs;
  logic signed [PROD_W-1:0] prod;
  logic [THR_W-1:0]        thr;
  logic signed [RATE_W-1:0] rate [3];
  logic                    done_flag;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             run_end;
  logic             unit_done;
  logic [Q_W-1:0]   unit_result;
  unit_req_t        unit_req;
  logic [VAR_W-1:0] var_d;
  logic [Q_W-1:0]   dividend;
  logic [SUM_W-1:0] smag;
  logic             last_axis;

  assign cfg_ready = 1'b1;

  // effective sample count: zero reads as one, capped at the maximum
  always_comb begin
    if (sample_count == '0)
      n_eff = CNT_W'(1);
    else if (sample_count > CNT_W'(MAX_SAMPLES))
      n_eff = CNT_W'(MAX_SAMPLES);
    else
      n_eff = sample_count;
  end

  assign cnt_inc   = sample_counter + 1'b1;
  assign run_end   = (cnt_inc >= n_eff);
  assign last_axis = (axis == 2'd2);
  assign smag      = axis_sum[axis][SUM_W-1] ? SUM_W'(-axis_sum[axis])
                                             : SUM_W'(axis_sum[axis]);
  assign var_d     = (lhs > rhs) ? (lhs - rhs) : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid && s_tready) state_next = s_tuser ? ST_ACC : ST_MEAS_MUL;
      ST_ACC:      state_next = run_end ? ST_CAL_MUL : ST_FINISH;
      ST_CAL_MUL:  state_next = ST_CAL_SUB;
      ST_CAL_SUB:  state_next = ST_CAL_SQRT;
      ST_CAL_SQRT: if (unit_done) state_next = ST_CAL_DIVS;
      ST_CAL_DIVS: if (unit_done) state_next = ST_CAL_DIVO;
      ST_CAL_DIVO: if (unit_done) state_next = last_axis ? ST_FINISH : ST_CAL_MUL;
      ST_MEAS_MUL: state_next = ST_MEAS_RND;
      ST_MEAS_RND: state_next = last_axis ? ST_FINISH : ST_MEAS_MUL;
      ST_FINISH:   if (!m_tvalid) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // unit requests and operands
  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = OP_DIV;
    dividend       = Q_W'(unit_result);
    case (state)
      ST_CAL_SUB: begin
        unit_req.start = 1'b1;
        unit_req.op    = OP_SQRT;
      end
      ST_CAL_SQRT: begin
        unit_req.start = unit_done;
        dividend       = unit_result;
      end
      ST_CAL_DIVS: begin
        unit_req.start = unit_done;
        dividend       = Q_W'({smag, {FRAC_BITS{1'b0}}}) + Q_W'(n_eff >> 1);
      end
      default: begin
        unit_req.start = 1'b0;
      end
    endcase
  end

  gbcd_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .req      (unit_req),
    .radicand (var_d),
    .dividend (dividend),
    .divisor  (n_eff),
    .done     (unit_done),
    .result   (unit_result)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count       <= CNT_W'(50);
      threshold_multiple <= '0;
      scale_select       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count       <= cfg_data;
        CFG_THRESHOLD:    threshold_multiple <= cfg_data[MULT_W-1:0];
        CFG_SCALE:        scale_select       <= cfg_data[1:0];
        default:          ;
      endcase
    end
  end

  // measure datapath terms
  logic signed [OFF_W-1:0] diff;
  logic [PROD_W-1:0]       pmag;
  logic [QMAG_W-1:0]       qmag;
  logic [RATE_W:0]         cmag;
  logic signed [RATE_W-1:0] rate_sat;

  always_comb begin
    diff = OFF_W'({{(OFF_W-RAW_W-FRAC_BITS){raw[axis][RAW_W-1]}}, raw[axis],
                   {FRAC_BITS{1'b0}}});
    if (calibrated_flag) diff = diff - axis_offset[axis];
    pmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    qmag = QMAG_W'((pmag + (PROD_W'(1) << (FRAC_BITS+15))) >> (FRAC_BITS+16));
    if (prod[PROD_W-1]) begin
      if (qmag > QMAG_W'(RATE_MAX_MAG) + QMAG_W'(1))
        cmag = (RATE_W+1)'(RATE_MAX_MAG) + 1'b1;
      else
        cmag = qmag[RATE_W:0];
      rate_sat = RATE_W'(-cmag);
    end else begin
      if (qmag > QMAG_W'(RATE_MAX_MAG)) cmag = (RATE_W+1)'(RATE_MAX_MAG);
      else                              cmag = qmag[RATE_W:0];
      rate_sat = RATE_W'(cmag);
    end
    if (threshold_multiple != '0 && THR_W'(cmag) < thr) rate_sat = '0;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        axis_sum[a]         <= '0;
        axis_sum_squares[a] <= '0;
        axis_offset[a]      <= '0;
        axis_spread[a]      <= '0;
      end
      sample_counter  <= '0;
      calibrated_flag <= 1'b0;
      axis            <= '0;
      done_flag       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            func   <= s_tuser;
            raw[0] <= s_tdata[15:0];
            raw[1] <= s_tdata[31:16];
            raw[2] <= s_tdata[47:32];
            axis   <= '0;
            for (int a = 0; a < 3; a++) rate[a] <= '0;
            done_flag <= 1'b0;
          end
        end
        ST_ACC: begin
          for (int a = 0; a < 3; a++) begin
            axis_sum[a] <= axis_sum[a] + SUM_W'(raw[a]);
            axis_sum_squares[a] <= axis_sum_squares[a]
                                   + SQ_W'(SQR_W'(raw[a] * raw[a]));
          end
          sample_counter <= cnt_inc;
          done_flag      <= run_end;
        end
        ST_CAL_MUL: begin
          lhs <= VAR_W'(n_eff * axis_sum_squares[axis]);
          rhs <= VAR_W'(smag * smag);
        end
        ST_CAL_DIVS: begin
          if (unit_done)
            axis_spread[axis] <= (unit_result > Q_W'(SPREAD_MAX)) ? SPREAD_MAX
                                                                  : unit_result[SPR_W-1:0];
        end
        ST_CAL_DIVO: begin
          if (unit_done) begin
            axis_offset[axis] <= axis_sum[axis][SUM_W-1] ? OFF_W'(-unit_result)
                                                         : OFF_W'(unit_result);
            axis <= axis + 1'b1;
            if (last_axis) begin
              for (int a = 0; a < 3; a++) begin
                axis_sum[a]         <= '0;
                axis_sum_squares[a] <= '0;
              end
              sample_counter  <= '0;
              calibrated_flag <= 1'b1;
            end
          end
        end
        ST_MEAS_MUL: begin
          prod <= diff * $signed({1'b0, gain_q24(scale_select)});
          thr  <= axis_spread[axis] * threshold_multiple;
        end
        ST_MEAS_RND: begin
          rate[axis] <= rate_sat;
          axis       <= axis + 1'b1;
        end
        ST_FINISH: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, rate[2], rate[1], rate[0]};
            m_tuser  <= {calibrated_flag, func & done_flag};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gbcd_checker.sv -----
module gbcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // one sample at a time: busy right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous sample in work");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a completed run leaves the block calibrated
  a_done_cal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("run completed without calibrated flag");

  // a sample that completes a calibration run carries zero rates
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
    else $error("nonzero rate on calibration result");

endmodule

bind gyro_bias_calibrate_deadband_core gbcd_checker u_gbcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import gbcd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [20:0] rate_x;
    logic signed [20:0] rate_y;
    logic signed [20:0] rate_z;
    logic               calib_done;
    logic               is_calibrated;
  } rate_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  gyro_bias_calibrate_deadband_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  longint     acc_sum [3];
  longint     acc_sq [3];
  int         cal_count;
  longint     bias_off [3];
  longint     noise_spread [3];
  bit         have_cal;
  int         cnt_reg;
  int         mult_reg;
  int         scale_reg;

  rate_result_t expected_rates [$];
  int           error_count;
  longint       cycle_count;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  // floor(sqrt(d * 2^16)), digit by digit over a 128-bit radicand
  function automatic longint scaled_sqrt(longint d);
    logic [127:0] x;
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    x = 128'(d) << (2 * FRAC_BITS);
    root = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((x >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic longint scale_gain(int sel);
    case (sel)
      0:       return 128060;
      1:       return 256138;
      2:       return 511487;
      default: return 1022991;
    endcase
  endfunction

  function automatic rate_result_t predict_rates(bit calib, logic [47:0] raw_bits);
    rate_result_t r;
    longint raw [3];
    longint n, smag, d, sp, diff, rate, lhs, rhs;
    longint rates [3];
    for (int a = 0; a < 3; a++)
      raw[a] = longint'($signed(raw_bits[16*a +: 16]));
    r.calib_done = 1'b0;
    if (calib) begin
      n = cnt_reg == 0 ? 1 : (cnt_reg > MAX_SAMPLES ? MAX_SAMPLES : cnt_reg);
      for (int a = 0; a < 3; a++) begin
        acc_sum[a] += raw[a];
        acc_sq[a] += raw[a] * raw[a];
      end
      cal_count++;
      if (cal_count >= n) begin
        for (int a = 0; a < 3; a++) begin
          smag = acc_sum[a] < 0 ? -acc_sum[a] : acc_sum[a];
          lhs = n * acc_sq[a];
          rhs = smag * smag;
          d = lhs > rhs ? lhs - rhs : 0;
          sp = scaled_sqrt(d) / n;
          bias_off[a] = round_div(acc_sum[a] * 256, n);
          noise_spread[a] = sp > 16777215 ? 16777215 : sp;
          acc_sum[a] = 0;
          acc_sq[a] = 0;
        end
        cal_count = 0;
        have_cal = 1'b1;
        r.calib_done = 1'b1;
      end
      rates = '{0, 0, 0};
    end else begin
      for (int a = 0; a < 3; a++) begin
        diff = raw[a] * 256;
        if (have_cal) diff -= bias_off[a];
        rate = round_div(diff * scale_gain(scale_reg), longint'(1) << 24);
        if (rate > 1048575) rate = 1048575;
        if (rate < -1048576) rate = -1048576;
        if (mult_reg != 0) begin
          lhs = (rate < 0 ? -rate : rate) * 256;
          rhs = noise_spread[a] * mult_reg * 256;
          if (lhs < rhs) rate = 0;
        end
        rates[a] = rate;
      end
    end
    r.rate_x = rates[0][20:0];
    r.rate_y = rates[1][20:0];
    r.rate_z = rates[2][20:0];
    r.is_calibrated = have_cal;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver: stall pattern and result check
  always @(posedge clk) begin
    rate_result_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 7) != 0) || (cycle_count[9:8] == 2'd0);
      if (m_tvalid && m_tready) begin
        if (expected_rates.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[20:0], 0);
        end else begin
          w = expected_rates.pop_front();
          if ($signed(m_tdata[20:0]) != w.rate_x)
            report_mismatch("rate_x", $signed(m_tdata[20:0]), w.rate_x);
          if ($signed(m_tdata[41:21]) != w.rate_y)
            report_mismatch("rate_y", $signed(m_tdata[41:21]), w.rate_y);
          if ($signed(m_tdata[62:42]) != w.rate_z)
            report_mismatch("rate_z", $signed(m_tdata[62:42]), w.rate_z);
          if (m_tuser[0] != w.calib_done)
            report_mismatch("calib_done", m_tuser[0], w.calib_done);
          if (m_tuser[1] != w.is_calibrated)
            report_mismatch("is_calibrated", m_tuser[1], w.is_calibrated);
        end
      end
    end
  end

  // send one request, with burst/gap idling before it
  task automatic send_sample(bit calib, logic [47:0] raw_bits);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= calib;
    s_tdata  <= raw_bits;
    expected_rates.push_back(predict_rates(calib, raw_bits));
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    // block is busy right after an accept; the task idles past it before the next request
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SAMPLE_COUNT: cnt_reg = int'(value);
      CFG_THRESHOLD:    mult_reg = int'(value[7:0]);
      CFG_SCALE:        scale_reg = int'(value[1:0]);
      default: ;
    endcase
  endtask

  function automatic logic [47:0] noisy_sample(int center, int spread);
    logic [47:0] v;
    for (int a = 0; a < 3; a++)
      v[16*a +: 16] = 16'(center + $urandom_range(0, 2 * spread) - spread);
    return v;
  endfunction

  // extremes before calibration, at every scale
  task automatic test_uncalibrated_extremes();
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_SCALE, 11'(s));
      send_sample(1'b0, {16'h8000, 16'h7fff, 16'h0000});
      send_sample(1'b0, {16'h0001, 16'hffff, 16'h8000});
    end
  endtask

  // one-sample calibration at the rails, unknown index, count zero and count too large
  task automatic test_calibration_edges();
    write_reg(CFG_UNUSED, 11'd5);
    write_reg(CFG_SAMPLE_COUNT, 11'd0);
    send_sample(1'b1, {16'h7fff, 16'h8000, 16'h1234});
    send_sample(1'b0, {16'h8000, 16'h7fff, 16'h1234});
    write_reg(CFG_SAMPLE_COUNT, 11'd2);
    send_sample(1'b1, {16'h8000, 16'h8000, 16'h7fff});
    send_sample(1'b1, {16'h7fff, 16'h8000, 16'h8000});
    write_reg(CFG_THRESHOLD, 11'd255);
    send_sample(1'b0, {16'h7fff, 16'h0000, 16'h8000});
    write_reg(CFG_THRESHOLD, 11'd1);
    send_sample(1'b0, {16'h7fff, 16'h0000, 16'h8000});
    // count lowered mid-run
    write_reg(CFG_SAMPLE_COUNT, 11'd5);
    send_sample(1'b1, 48'h0003_fffd_0010);
    send_sample(1'b1, 48'h0005_fff0_0020);
    write_reg(CFG_SAMPLE_COUNT, 11'd1);
    send_sample(1'b1, 48'h0001_0002_0003);
    write_reg(CFG_SAMPLE_COUNT, 11'd2047);
    repeat (1100) send_sample(1'b1, noisy_sample($urandom_range(0, 200) - 100, 50));
  endtask

  // random phases: calibration runs then measurements near the bias
  task automatic test_random_runs();
    int center;
    int noise;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_SAMPLE_COUNT, 11'($urandom_range(1, 24)));
      write_reg(CFG_THRESHOLD, ph % 3 == 0 ? 11'd0 : 11'($urandom_range(1, 255)));
      write_reg(CFG_SCALE, 11'($urandom_range(0, 3)));
      center = $urandom_range(0, 4000) - 2000;
      noise = $urandom_range(0, 3) == 0 ? 3000 : $urandom_range(0, 40);
      repeat (cnt_reg) send_sample(1'b1, noisy_sample(center, noise));
      repeat ($urandom_range(20, 40)) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}));
        else
          send_sample(1'b0, noisy_sample(center, $urandom_range(1, 200) * (noise + 1)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SAMPLE_COUNT;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    for (int a = 0; a < 3; a++) begin
      acc_sum[a] = 0;
      acc_sq[a] = 0;
      bias_off[a] = 0;
      noise_spread[a] = 0;
    end
    cal_count = 0;
    have_cal = 1'b0;
    cnt_reg = 50;
    mult_reg = 0;
    scale_reg = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_uncalibrated_extremes();
    test_calibration_edges();
    test_random_runs();

    while (expected_rates.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
